// ===== rtl/core/address_range_table_macros.svh =====
// Assertion macros shared by the address range table RTL.
`ifndef ADDRESS_RANGE_TABLE_MACROS_SVH
`define ADDRESS_RANGE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ART_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("address_range_table: check failed");

// Next-cycle implication, disabled while reset is held.
`define ART_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("address_range_table: check failed");

`endif

// ===== rtl/core/art_pkg.sv =====
// Shared types, sizes and codes of the address range table.
package art_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_BITS   = 48;
	localparam int TAG_BITS    = 32;
	localparam int SLOT_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERLAP  = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [ADDR_BITS-1:0] start_addr;
		logic [ADDR_BITS-1:0] end_addr;
		logic [TAG_BITS-1:0]  user_tag;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic                hit;
		logic [TAG_BITS-1:0] found_tag;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic commit;
	} ctrl_t;

	// Datapath to controller
	typedef struct packed {
		logic last_issue;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/core/art_req_if.sv =====
// Command channel: valid/ready handshake with the command beat.
interface art_req_if;
	import art_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           cmd;
	logic [ADDR_BITS-1:0] start_addr;
	logic [ADDR_BITS-1:0] end_addr;
	logic [TAG_BITS-1:0]  user_tag;

	modport source (output valid, output cmd, output start_addr, output end_addr,
		output user_tag, input ready);
	modport sink (input valid, input cmd, input start_addr, input end_addr,
		input user_tag, output ready);
endinterface

// ===== rtl/core/art_rsp_if.sv =====
// Result channel: valid/ready handshake with the result beat.
interface art_rsp_if;
	import art_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic                hit;
	logic [TAG_BITS-1:0] found_tag;

	modport source (output valid, output status, output hit, output found_tag,
		input ready);
	modport sink (input valid, input status, input hit, input found_tag,
		output ready);
endinterface

// ===== rtl/core/art_ctrl.sv =====
// Command sequencer: accept, scan the slots, drain the compare stage, finish.
module art_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  art_pkg::stat_t stat,
	output art_pkg::ctrl_t ctrl
);
	import art_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.last_issue) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		ctrl.load   = 1'b0;
		ctrl.issue  = 1'b0;
		ctrl.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			S_SCAN: begin
				ctrl.issue = 1'b1;
			end
			S_DRAIN: begin
			end
			S_FIN: begin
				// hold the finished result until the output register frees up
				ctrl.commit = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/art_dp.sv =====
// Slot store, one shared compare stage, result logic and output register.
module art_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  art_pkg::ctrl_t ctrl,
	output art_pkg::stat_t stat,
	input  art_pkg::req_t  req_pl,
	output logic           out_valid,
	input  logic           out_ready,
	output art_pkg::rsp_t  out_pl
);
	import art_pkg::*;

	// slot store
	logic [TABLE_DEPTH-1:0] slot_valid_q;
	logic [ADDR_BITS-1:0]   slot_start_q [TABLE_DEPTH];
	logic [ADDR_BITS-1:0]   slot_end_q   [TABLE_DEPTH];
	logic [TAG_BITS-1:0]    slot_tag_q   [TABLE_DEPTH];

	// captured command
	cmd_t                 cmd_q;
	logic [ADDR_BITS-1:0] s_q;
	logic [ADDR_BITS-1:0] e_q;
	logic [TAG_BITS-1:0]  tag_q;

	logic [SLOT_BITS-1:0] idx_q;

	// read stage
	logic                 live_s1;
	logic                 vld_s1;
	logic [SLOT_BITS-1:0] idx_s1;
	logic [ADDR_BITS-1:0] start_s1;
	logic [ADDR_BITS-1:0] end_s1;
	logic [TAG_BITS-1:0]  tag_s1;

	// scan results
	logic                 match_q;
	logic                 overlap_q;
	logic                 free_q;
	logic [SLOT_BITS-1:0] match_idx_q;
	logic [SLOT_BITS-1:0] free_idx_q;
	logic [TAG_BITS-1:0]  match_tag_q;

	logic  out_valid_q;
	rsp_t  out_q;

	logic  same_start;
	logic  below_end;
	logic  covers;
	logic  meets;
	logic  sel_match;
	logic  inverted;
	rsp_t  res;
	logic  do_write;
	logic  do_clear;

	assign stat.last_issue = (idx_q == SLOT_BITS'(TABLE_DEPTH - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= req_pl.cmd;
			s_q   <= req_pl.start_addr;
			e_q   <= req_pl.end_addr;
			tag_q <= req_pl.user_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			live_s1 <= 1'b0;
		end else begin
			live_s1 <= ctrl.issue;
			if (ctrl.load) begin
				idx_q <= '0;
			end else if (ctrl.issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			vld_s1   <= slot_valid_q[idx_q];
			idx_s1   <= idx_q;
			start_s1 <= slot_start_q[idx_q];
			end_s1   <= slot_end_q[idx_q];
			tag_s1   <= slot_tag_q[idx_q];
		end
	end

	// compare one slot against the captured command
	assign same_start = (start_s1 == s_q);
	assign below_end  = (s_q < end_s1);
	assign covers     = (s_q >= start_s1) && below_end;
	assign meets      = (start_s1 < e_q) && below_end;
	assign sel_match  = (cmd_q == CMD_FIND) ? covers : same_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q   <= 1'b0;
			overlap_q <= 1'b0;
			free_q    <= 1'b0;
		end else if (ctrl.load) begin
			match_q   <= 1'b0;
			overlap_q <= 1'b0;
			free_q    <= 1'b0;
		end else if (live_s1) begin
			if (vld_s1) begin
				if (same_start || meets) overlap_q <= 1'b1;
				if (sel_match && !match_q) match_q <= 1'b1;
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	// keep the first matching slot and the lowest free slot
	always_ff @(posedge clk) begin
		if (live_s1) begin
			if (vld_s1 && sel_match && !match_q) begin
				match_idx_q <= idx_s1;
				match_tag_q <= tag_s1;
			end
			if (!vld_s1 && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	assign inverted = (e_q <= s_q);

	always_comb begin
		res      = '{status: ST_OK, hit: 1'b0, found_tag: '0};
		do_write = 1'b0;
		do_clear = 1'b0;
		case (cmd_q)
			CMD_ADD: begin
				if (inverted || overlap_q) begin
					res.status = ST_OVERLAP;
				end else if (!free_q) begin
					res.status = ST_FULL;
				end else begin
					do_write = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (match_q) begin
					do_clear = 1'b1;
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			CMD_FIND: begin
				if (match_q) begin
					res.hit       = 1'b1;
					res.found_tag = match_tag_q;
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (ctrl.commit) begin
			if (do_write) slot_valid_q[free_idx_q] <= 1'b1;
			if (do_clear) slot_valid_q[match_idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit && do_write) begin
			slot_start_q[free_idx_q] <= s_q;
			slot_end_q[free_idx_q]   <= e_q;
			slot_tag_q[free_idx_q]   <= tag_q;
		end
	end

	// output register: load on commit, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_pl    = out_q;

endmodule

// ===== rtl/core/address_range_table.sv =====
// Top level of the address range table: channels, sequencer and datapath.
`include "address_range_table_macros.svh"

// Keeps up to TABLE_DEPTH (16) disjoint half-open ranges [start, end) with a tag each and
// takes one command beat at a time: add, remove by start, or find an address. Every
// command reads all slots through a single slot read port into one compare stage, one
// slot per cycle. Its result reaches the output register after the reads of all slots,
// the compare of the last slot in the drain state and the finish state. The next command
// is taken in the cycle after the result is registered. The previous result may still
// wait in the output register meanwhile; the finish state holds until that register is free.
// A successful add goes to the lowest free slot; an add that is empty, inverted
// or meets a stored range is refused with the overlap status before fullness is checked.
module address_range_table (
	input  logic clk,
	input  logic arst_n,
	art_req_if.sink   req,
	art_rsp_if.source resp
);
	import art_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	req_t  req_pl;
	rsp_t  out_pl;
	logic  in_ready;
	logic  out_valid;

	assign req_pl.cmd        = cmd_t'(req.cmd);
	assign req_pl.start_addr = req.start_addr;
	assign req_pl.end_addr   = req.end_addr;
	assign req_pl.user_tag   = req.user_tag;
	assign req.ready         = in_ready;

	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	art_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.req_pl    (req_pl),
		.out_valid (out_valid),
		.out_ready (resp.ready),
		.out_pl    (out_pl)
	);

	assign resp.valid     = out_valid;
	assign resp.status    = out_pl.status;
	assign resp.hit       = out_pl.hit;
	assign resp.found_tag = out_pl.found_tag;

	`ART_ASSERT_IMPL(a_one_cmd, clk, arst_n, 1'b1, $onehot0({ctrl.load, ctrl.issue, ctrl.commit}))
	`ART_ASSERT_NEXT(a_one_item, clk, arst_n, req.valid && req.ready, !req.ready)
	`ART_ASSERT_NEXT(a_commit_shows, clk, arst_n, ctrl.commit, resp.valid)
	`ART_ASSERT_IMPL(a_hit_ok, clk, arst_n, resp.valid && resp.hit, resp.status == ST_OK)

endmodule
